FILE: rtl/tcpc_pkg.sv
`timescale 1ns / 1ps

package tcpc_pkg;

  localparam int ROW_W  = 64;
  localparam int PAIR_W = 13;
  localparam int CFG_W  = 7;
  localparam int BYTE_N = ROW_W / 8;

  typedef enum logic [2:0] {
    S_LOAD,
    S_CLOSE,
    S_COUNT,
    S_DRAIN,
    S_EMIT
  } tcpc_state_e;

  typedef struct packed {
    logic load;
    logic clear;
    logic shift;
    logic or_en;
  } tcpc_lane_ctrl_t;

endpackage

FILE: rtl/tcpc_lane.sv
`timescale 1ns / 1ps

module tcpc_lane #(
  parameter int NODES = 64,
  parameter int IW    = $clog2(NODES)
) (
  input  logic                       clk_i,
  input  tcpc_pkg::tcpc_lane_ctrl_t  ctrl_i,
  input  logic                       sel_i,
  input  logic [NODES-1:0]           load_row_i,
  input  logic [NODES-1:0]           pivot_i,
  input  logic [IW-1:0]              pivot_idx_i,
  input  logic [NODES-1:0]           next_i,
  output logic [NODES-1:0]           row_o,
  output logic [NODES-1:0]           upd_o
);
  import tcpc_pkg::*;

  logic [NODES-1:0] row_q, row_d;

  // row ORs in the pivot row when it reaches the pivot node
  assign upd_o = (ctrl_i.or_en && row_q[pivot_idx_i]) ? (row_q | pivot_i) : row_q;
  assign row_o = row_q;

  always_comb begin
    row_d = row_q;
    if (ctrl_i.shift) begin
      row_d = next_i;
    end else if (ctrl_i.load && sel_i) begin
      row_d = load_row_i;
    end else if (ctrl_i.load && ctrl_i.clear) begin
      row_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q <= row_d;
  end

endmodule

FILE: rtl/tcpc_lane_array.sv
`timescale 1ns / 1ps

module tcpc_lane_array #(
  parameter int NODES = 64,
  parameter int IW    = $clog2(NODES)
) (
  input  logic                       clk_i,
  input  tcpc_pkg::tcpc_lane_ctrl_t  ctrl_i,
  input  logic [IW-1:0]              load_idx_i,
  input  logic [NODES-1:0]           load_row_i,
  input  logic [IW-1:0]              pivot_idx_i,
  output logic [NODES-1:0]           head_o
);
  import tcpc_pkg::*;

  logic [NODES-1:0] row_w [NODES];
  logic [NODES-1:0] upd_w [NODES];

  for (genvar p = 0; p < NODES; p++) begin : g_lane
    tcpc_lane #(
      .NODES(NODES),
      .IW   (IW)
    ) u_lane (
      .clk_i      (clk_i),
      .ctrl_i     (ctrl_i),
      .sel_i      (load_idx_i == IW'(p)),
      .load_row_i (load_row_i),
      .pivot_i    (row_w[0]),
      .pivot_idx_i(pivot_idx_i),
      .next_i     (upd_w[(p + 1) % NODES]),
      .row_o      (row_w[p]),
      .upd_o      (upd_w[p])
    );
  end

  assign head_o = row_w[0];

endmodule

FILE: rtl/tcpc_merge.sv
`timescale 1ns / 1ps

module tcpc_merge #(
  parameter int NODES = 64,
  parameter int CW    = $clog2(NODES * NODES + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  logic             clear_i,
  input  logic [NODES-1:0] row_i,
  output logic [CW-1:0]    count_o
);
  import tcpc_pkg::*;

  localparam int PW = $clog2(ROW_W + 1);

  logic [ROW_W-1:0] row_w;
  logic [3:0]       byte_cnt_d [BYTE_N];
  logic [3:0]       byte_cnt_q [BYTE_N];
  logic [PW-1:0]    pop_d, pop_q;
  logic             v1_q, v2_q;
  logic [CW-1:0]    acc_q, acc_d;

  assign row_w = ROW_W'(row_i);

  always_comb begin
    for (int b = 0; b < BYTE_N; b++) begin
      byte_cnt_d[b] = '0;
      for (int j = 0; j < 8; j++) begin
        byte_cnt_d[b] = byte_cnt_d[b] + 4'(row_w[b*8 + j]);
      end
    end
  end

  always_comb begin
    pop_d = '0;
    for (int b = 0; b < BYTE_N; b++) begin
      pop_d = pop_d + PW'(byte_cnt_q[b]);
    end
  end

  always_comb begin
    acc_d = acc_q;
    if (clear_i) begin
      acc_d = '0;
    end else if (v2_q) begin
      acc_d = CW'(acc_q + CW'(pop_q));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      acc_q <= '0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_cnt_q <= byte_cnt_d;
    pop_q      <= pop_d;
  end

  assign count_o = acc_q;

endmodule

FILE: rtl/transitive_closure_pair_count_core.sv
`timescale 1ns / 1ps

// Reflexive transitive closure of a directed graph with a count of reachable ordered
// pairs. Rows of the adjacency matrix arrive one per request, row 0 first, at one row
// per cycle while the core is loading; bits at or above node_count are dropped and
// each diagonal bit is set. Every row sits in its own lane register; the lanes form
// a ring that rotates by one each closure step, so the pivot row is always at the
// head and all lanes apply it in the same cycle. After the closure steps the ring
// rotates once more through all MAX_NODES lanes while a popcount merge stage sums
// the rows. Rows of the next graph are taken while a result waits to be read.
// Writing node_count restarts the load at row 0; 0 acts as 1 and values above
// MAX_NODES as MAX_NODES.
module transitive_closure_pair_count_core #(
  parameter int MAX_NODES = 64
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tcpc_pkg::CFG_W-1:0]  cfg_wdata_i,   // node_count
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [tcpc_pkg::ROW_W-1:0]  s_axis_tdata,  // row_bits[63:0]
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [15:0]                 m_axis_tdata   // pair_count[12:0], zeros
);
  import tcpc_pkg::*;

  localparam int IW = $clog2(MAX_NODES);
  localparam int NW = $clog2(MAX_NODES + 1);
  localparam int CW = $clog2(MAX_NODES * MAX_NODES + 1);

  tcpc_state_e       state_q, state_d;
  logic [CFG_W-1:0]  node_count_q;
  logic [NW-1:0]     n_eff;
  logic [NW-1:0]     rows_q, rows_d;
  logic [IW-1:0]     k_q, k_d;
  logic [IW-1:0]     cnt_q, cnt_d;
  logic              drain_q, drain_d;
  logic              out_valid_q, out_valid_d;
  logic [PAIR_W-1:0] out_data_q;
  logic              emit;
  logic              in_fire;
  logic              row_last;
  logic              merge_clear;
  logic [MAX_NODES-1:0] load_row;
  logic [MAX_NODES-1:0] head_row;
  logic [CW-1:0]        count;
  tcpc_lane_ctrl_t      ctrl;

  always_comb begin
    if (node_count_q == '0) begin
      n_eff = NW'(1);
    end else if (node_count_q > CFG_W'(MAX_NODES)) begin
      n_eff = NW'(MAX_NODES);
    end else begin
      n_eff = NW'(node_count_q);
    end
  end

  assign s_axis_tready = (state_q == S_LOAD);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign row_last      = (NW'(rows_q + NW'(1)) == n_eff);

  always_comb begin
    for (int i = 0; i < MAX_NODES; i++) begin
      load_row[i] = (s_axis_tdata[i] && (NW'(i) < n_eff)) || (IW'(i) == rows_q[IW-1:0]);
    end
  end

  always_comb begin
    state_d     = state_q;
    rows_d      = rows_q;
    k_d         = k_q;
    cnt_d       = cnt_q;
    drain_d     = drain_q;
    emit        = 1'b0;
    merge_clear = 1'b0;
    ctrl        = '0;
    case (state_q)
      S_LOAD: begin
        if (in_fire) begin
          ctrl.load  = 1'b1;
          ctrl.clear = (rows_q == '0);
          if (row_last) begin
            rows_d  = '0;
            k_d     = '0;
            state_d = S_CLOSE;
          end else begin
            rows_d = NW'(rows_q + NW'(1));
          end
        end
      end
      S_CLOSE: begin
        ctrl.shift = 1'b1;
        ctrl.or_en = 1'b1;
        if (NW'(k_q) == NW'(n_eff - NW'(1))) begin
          merge_clear = 1'b1;
          cnt_d       = '0;
          state_d     = S_COUNT;
        end else begin
          k_d = IW'(k_q + IW'(1));
        end
      end
      S_COUNT: begin
        ctrl.shift = 1'b1;
        if (cnt_q == IW'(MAX_NODES - 1)) begin
          drain_d = 1'b0;
          state_d = S_DRAIN;
        end else begin
          cnt_d = IW'(cnt_q + IW'(1));
        end
      end
      S_DRAIN: begin
        drain_d = 1'b1;
        if (drain_q) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || m_axis_tready) begin
          emit    = 1'b1;
          state_d = S_LOAD;
        end
      end
      default: begin
        state_d = S_LOAD;
      end
    endcase
    if (cfg_we_i) begin
      rows_d = '0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_LOAD;
      node_count_q <= CFG_W'(64);
      rows_q       <= '0;
      k_q          <= '0;
      cnt_q        <= '0;
      drain_q      <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      rows_q      <= rows_d;
      k_q         <= k_d;
      cnt_q       <= cnt_d;
      drain_q     <= drain_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_data_q <= PAIR_W'(count);
    end
  end

  tcpc_lane_array #(
    .NODES(MAX_NODES),
    .IW   (IW)
  ) u_lanes (
    .clk_i      (clk_i),
    .ctrl_i     (ctrl),
    .load_idx_i (rows_q[IW-1:0]),
    .load_row_i (load_row),
    .pivot_idx_i(k_q),
    .head_o     (head_row)
  );

  tcpc_merge #(
    .NODES(MAX_NODES),
    .CW   (CW)
  ) u_merge (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(state_q == S_COUNT),
    .clear_i(merge_clear),
    .row_i  (head_row),
    .count_o(count)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = 16'(out_data_q);

  a_rows_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_q < n_eff)
    else $error("row counter past node count");

  a_pivot_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLOSE) |-> (NW'(k_q) < n_eff))
    else $error("pivot index past node count");

  a_valid_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == S_EMIT))
    else $error("result raised outside emit");

  a_count_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[PAIR_W-1:0] != '0))
    else $error("pair count of zero");

  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CLOSE || state_q == S_COUNT) |-> !s_axis_tready)
    else $error("row taken during closure");

endmodule

FILE: bench/tb_transitive_closure_pair_count_core.sv
`timescale 1ns / 1ps

module tb_transitive_closure_pair_count_core;
  import tcpc_pkg::*;

  localparam int NODES_MAX    = 64;
  localparam int SETTLE_CYCLES = 2 * NODES_MAX + 16;
  localparam int RANDOM_ROWS  = 650;
  localparam int SQUEEZE_CYCLES = 400;

  typedef enum logic {
    STEP_ROW,
    STEP_CFG
  } step_kind_e;

  typedef struct packed {
    step_kind_e          kind;
    logic [ROW_W-1:0]    value;
    logic                typed;
    logic [PAIR_W-1:0]   pairs;
  } step_t;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_COIN,
    RX_TIGHT
  } rx_mode_e;

  typedef enum logic [2:0] {
    FILL_NONE,
    FILL_SPARSE,
    FILL_COIN,
    FILL_FULL,
    FILL_RING,
    FILL_DENSE
  } fill_e;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_W-1:0]  cfg_wdata_i;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [ROW_W-1:0]  s_axis_tdata;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [15:0]       m_axis_tdata;

  // predictor state
  logic [ROW_W-1:0]  reach_rows [NODES_MAX];
  int unsigned       loaded_rows;
  logic [CFG_W-1:0]  nodes_reg;

  logic [PAIR_W-1:0] pairs_due [$];
  int                mismatch_count;
  int unsigned       burst_left;
  bit                squeeze_go;
  step_t             script [26];

  transitive_closure_pair_count_core #(
    .MAX_NODES(NODES_MAX)
  ) DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int unsigned active_nodes(input logic [CFG_W-1:0] code);
    if (code == 0) begin
      return 1;
    end
    if (code > NODES_MAX) begin
      return NODES_MAX;
    end
    return 32'(code);
  endfunction

  // stores one row; returns 1 with the pair count when the graph is complete
  function automatic bit absorb_row(input logic [ROW_W-1:0] row,
                                    output logic [PAIR_W-1:0] pairs);
    int unsigned n;
    int unsigned r;
    int unsigned total;
    logic [ROW_W-1:0] keep;
    logic [ROW_W-1:0] pivot;
    n = active_nodes(nodes_reg);
    keep = (n >= ROW_W) ? '1 : ((64'd1 << n) - 64'd1);
    r = (loaded_rows >= n) ? 0 : loaded_rows;
    reach_rows[r] = (row & keep) | (64'd1 << r);
    r++;
    pairs = '0;
    if (r < n) begin
      loaded_rows = r;
      return 1'b0;
    end
    loaded_rows = 0;
    for (int k = 0; k < n; k++) begin
      pivot = reach_rows[k];
      for (int i = 0; i < n; i++) begin
        if (reach_rows[i][k]) begin
          reach_rows[i] = reach_rows[i] | pivot;
        end
      end
    end
    total = 0;
    for (int i = 0; i < n; i++) begin
      total += $countones(reach_rows[i]);
    end
    pairs = total[PAIR_W-1:0];
    return 1'b1;
  endfunction

  task automatic send_row(input logic [ROW_W-1:0] row, input logic typed,
                          input logic [PAIR_W-1:0] typed_pairs);
    int unsigned gap;
    logic [PAIR_W-1:0] pairs;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= row;
    do @(posedge clk_i); while (!s_axis_tready);
    if (absorb_row(row, pairs)) begin
      pairs_due.push_back(typed ? typed_pairs : pairs);
    end
    @(negedge clk_i);
  endtask

  // only while idle: all results in and the closure pass settled
  task automatic write_nodes(input logic [CFG_W-1:0] code);
    s_axis_tvalid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= code;
    nodes_reg   = code;
    loaded_rows = 0;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pairs_due.size() == 0) begin
        $display("%0t: unexpected pair count %0d, none expected", $time, m_axis_tdata);
        mismatch_count++;
      end else begin
        logic [PAIR_W-1:0] want;
        want = pairs_due.pop_front();
        if (m_axis_tdata !== {{(16 - PAIR_W){1'b0}}, want}) begin
          $display("%0t: pair count expected %0d, got %0d", $time, want, m_axis_tdata);
          mismatch_count++;
        end
      end
    end
  end

  // receiver stall pattern
  initial begin
    rx_mode_e mode;
    int unsigned mode_left;
    int unsigned hold;
    bit squeeze_seen;
    m_axis_tready = 1'b0;
    mode = RX_OPEN;
    mode_left = 0;
    hold = 0;
    squeeze_seen = 1'b0;
    forever begin
      @(negedge clk_i);
      if (squeeze_go && !squeeze_seen) begin
        squeeze_seen = 1'b1;
        hold = SQUEEZE_CYCLES;
      end
      if (hold != 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode = rx_mode_e'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 200);
        end
        mode_left--;
        case (mode)
          RX_OPEN:  m_axis_tready <= 1'b1;
          RX_COIN:  m_axis_tready <= 1'($urandom_range(0, 1));
          default:  m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // stimulus
  initial begin
    int rows_left;
    int unsigned phase;
    int unsigned sel;
    int unsigned n;
    int unsigned graphs;
    int unsigned tail;
    logic [CFG_W-1:0] code;
    fill_e fill;
    logic [ROW_W-1:0] a;
    logic [ROW_W-1:0] b;
    logic [ROW_W-1:0] c;
    logic [ROW_W-1:0] row;

    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_wdata_i   = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    mismatch_count = 0;
    burst_left    = 0;
    squeeze_go    = 1'b0;
    nodes_reg     = 7'd64;
    loaded_rows   = 0;
    foreach (reach_rows[i]) reach_rows[i] = '0;

    script = '{
      '{STEP_CFG, 64'd1,                    1'b0, 13'd0},
      '{STEP_ROW, 64'd0,                    1'b1, 13'd1},
      '{STEP_ROW, {ROW_W{1'b1}},            1'b1, 13'd1},
      '{STEP_CFG, 64'd0,                    1'b0, 13'd0},  // zero acts as one node
      '{STEP_ROW, {ROW_W{1'b1}},            1'b1, 13'd1},
      '{STEP_CFG, 64'd2,                    1'b0, 13'd0},
      '{STEP_ROW, 64'h2,                    1'b0, 13'd0},
      '{STEP_ROW, 64'h0,                    1'b1, 13'd3},
      '{STEP_ROW, {ROW_W{1'b1}},            1'b0, 13'd0},
      '{STEP_ROW, {ROW_W{1'b1}},            1'b1, 13'd4},
      '{STEP_ROW, 64'h0,                    1'b0, 13'd0},
      '{STEP_ROW, 64'h0,                    1'b1, 13'd2},
      '{STEP_CFG, 64'd3,                    1'b0, 13'd0},
      '{STEP_ROW, 64'h2,                    1'b0, 13'd0},  // ring of three
      '{STEP_ROW, 64'h4,                    1'b0, 13'd0},
      '{STEP_ROW, 64'h1,                    1'b1, 13'd9},
      '{STEP_ROW, 64'h2,                    1'b0, 13'd0},  // chain of three
      '{STEP_ROW, 64'h4,                    1'b0, 13'd0},
      '{STEP_ROW, 64'h0,                    1'b1, 13'd6},
      '{STEP_ROW, 64'hFFFF_FFFF_FFFF_FFF8,  1'b0, 13'd0},  // out-of-range columns
      '{STEP_ROW, 64'h0,                    1'b0, 13'd0},
      '{STEP_ROW, 64'h0,                    1'b1, 13'd3},
      '{STEP_ROW, 64'h2,                    1'b0, 13'd0},  // dropped by the write below
      '{STEP_CFG, 64'd2,                    1'b0, 13'd0},
      '{STEP_ROW, 64'h0,                    1'b0, 13'd0},
      '{STEP_ROW, 64'h1,                    1'b1, 13'd3}
    };

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (script[i]) begin
      if (script[i].kind == STEP_CFG) begin
        write_nodes(script[i].value[CFG_W-1:0]);
      end else begin
        send_row(script[i].value, script[i].typed, script[i].pairs);
      end
    end

    rows_left = RANDOM_ROWS;
    phase = 0;
    while (rows_left > 0) begin
      sel = $urandom_range(0, 9);
      if (sel <= 4) begin
        code = CFG_W'($urandom_range(1, 8));
      end else if (sel <= 6) begin
        code = CFG_W'($urandom_range(9, 40));
      end else if (sel == 7) begin
        code = CFG_W'($urandom_range(41, 127));
      end else if (sel == 8) begin
        case ($urandom_range(0, 3))
          0:       code = 7'd0;
          1:       code = 7'd1;
          2:       code = 7'd65;
          default: code = 7'd127;
        endcase
      end else begin
        code = 7'd64;
      end
      if (phase == 2) begin
        code = 7'd2;
      end
      write_nodes(code);
      n = active_nodes(code);
      graphs = $urandom_range(1, (n <= 40) ? 40 / n : 1);
      // long receiver hold-off while the sender keeps pushing graphs
      if (phase == 2) begin
        graphs = 40;
        squeeze_go = 1'b1;
      end
      for (int g = 0; g < graphs; g++) begin
        fill = fill_e'($urandom_range(0, 5));
        for (int r = 0; r < n; r++) begin
          a = {$urandom, $urandom};
          b = {$urandom, $urandom};
          c = {$urandom, $urandom};
          case (fill)
            FILL_NONE:   row = '0;
            FILL_SPARSE: row = a & b & c;
            FILL_COIN:   row = a;
            FILL_FULL:   row = '1;
            FILL_RING:   row = (64'd1 << ((r + 1) % n)) | (a & b & c & ~((64'd1 << n) - 64'd1));
            default:     row = a | b;
          endcase
          send_row(row, 1'b0, '0);
          rows_left--;
        end
      end
      // broken load left for the next write to discard
      if (n > 1 && $urandom_range(0, 3) == 0) begin
        tail = $urandom_range(1, n - 1);
        for (int r = 0; r < tail; r++) begin
          send_row({$urandom, $urandom}, 1'b0, '0);
          rows_left--;
        end
      end
      phase++;
    end

    s_axis_tvalid <= 1'b0;
    while (pairs_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: transitive_closure_pair_count_core.f
rtl/tcpc_pkg.sv
rtl/tcpc_lane.sv
rtl/tcpc_lane_array.sv
rtl/tcpc_merge.sv
rtl/transitive_closure_pair_count_core.sv
bench/tb_transitive_closure_pair_count_core.sv
